FILE: rtl/multi_channel_timeout_watchdog_top_macros.svh
// Assertion macros for the watchdog table.
`ifndef MULTI_CHANNEL_TIMEOUT_WATCHDOG_TOP_MACROS_SVH
`define MULTI_CHANNEL_TIMEOUT_WATCHDOG_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define MCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCW_ASSERT(lbl, prop, msg)
`define MCW_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/mcw_pkg.sv
package mcw_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int ID_W        = 32;
  localparam int TMO_W       = 32;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_KICK   = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic is_tick;
    logic out_busy;
    logic need_push;
    logic pend_valid;
  } dp_st_t;

endpackage

FILE: rtl/mcw_req_if.sv
interface mcw_req_if import mcw_pkg::*; ();
  logic             valid;
  logic             ready;
  cmd_e_t           cmd;
  logic [ID_W-1:0]  cmd_id;
  logic [TMO_W-1:0] timeout;

  modport source (output valid, cmd, cmd_id, timeout, input ready);
  modport sink (input valid, cmd, cmd_id, timeout, output ready);
endinterface

FILE: rtl/mcw_res_if.sv
interface mcw_res_if import mcw_pkg::*; ();
  logic            valid;
  logic            ready;
  kind_t           kind;
  status_t         status;
  logic [ID_W-1:0] expired_id;
  logic            last;

  modport source (output valid, kind, status, expired_id, last, input ready);
  modport sink (input valid, kind, status, expired_id, last, output ready);
endinterface

FILE: rtl/mcw_ctrl.sv
module mcw_ctrl import mcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_st_t   st,
  output ctl_cmd_t cmd
);

  state_t state, state_next;
  logic   fin_ok;

  assign fin_ok = !st.out_busy || (st.is_tick && !st.pend_valid);

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(st.need_push && st.out_busy)) begin
          cmd.step = 1'b1;
          if (st.scan_last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (fin_ok) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/mcw_datapath.sv
module mcw_datapath import mcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_e_t           in_cmd,
  input  logic [ID_W-1:0]  in_cmd_id,
  input  logic [TMO_W-1:0] in_timeout,
  input  ctl_cmd_t         cmd,
  output dp_st_t           st,
  mcw_res_if.source        res
);

  logic [SLOTS-1:0] slot_valid;
  logic [ID_W-1:0]  slot_id        [SLOTS];
  logic [TMO_W-1:0] slot_timeout   [SLOTS];
  logic [TMO_W-1:0] slot_remaining [SLOTS];

  cmd_e_t           op_cmd;
  logic [ID_W-1:0]  op_id;
  logic [TMO_W-1:0] op_tmo;
  logic [IDX_W-1:0] idx;
  logic             match_found;
  logic [IDX_W-1:0] match_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] exp_cnt;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  logic             out_valid;
  kind_t            out_kind;
  status_t          out_status;
  logic [ID_W-1:0]  out_id;
  logic             out_last;

  logic             is_tick;
  logic             cur_valid;
  logic             cur_due;
  logic             room;
  logic [IDX_W-1:0] sel_idx;
  logic             out_load;

  assign is_tick   = (op_cmd == CMD_TICK);
  assign cur_valid = slot_valid[idx];
  assign cur_due   = slot_remaining[idx] <= TMO_W'(1);
  assign room      = exp_cnt < CNT_W'(MAX_RESULTS);
  assign sel_idx   = match_found ? match_idx : free_idx;
  assign out_load  = (cmd.step && st.need_push) || (cmd.fin && (!is_tick || pend_valid));

  assign st.scan_last  = (idx == IDX_W'(SLOTS - 1));
  assign st.is_tick    = is_tick;
  assign st.out_busy   = out_valid && !res.ready;
  assign st.need_push  = is_tick && cur_valid && cur_due && room && pend_valid;
  assign st.pend_valid = pend_valid;

  assign res.valid      = out_valid;
  assign res.kind       = out_kind;
  assign res.status     = out_status;
  assign res.expired_id = out_id;
  assign res.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        op_cmd      <= in_cmd;
        op_id       <= in_cmd_id;
        op_tmo      <= in_timeout;
        idx         <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        exp_cnt     <= '0;
        pend_valid  <= 1'b0;
      end
      if (cmd.step) begin
        idx <= idx + 1'b1;
        if (is_tick) begin
          if (cur_valid) begin
            if (cur_due) begin
              if (room) begin
                slot_valid[idx] <= 1'b0;
                exp_cnt         <= exp_cnt + 1'b1;
                pend_valid      <= 1'b1;
                pend_id         <= slot_id[idx];
                if (pend_valid) begin
                  out_kind   <= KIND_EXPIRY;
                  out_status <= STS_OK;
                  out_id     <= pend_id;
                  out_last   <= 1'b0;
                end
              end else begin
                slot_remaining[idx] <= TMO_W'(1);
              end
            end else begin
              slot_remaining[idx] <= slot_remaining[idx] - 1'b1;
            end
          end
        end else begin
          if (cur_valid && slot_id[idx] == op_id && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= idx;
          end
          if (!cur_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
        end
      end
      if (cmd.fin) begin
        if (is_tick) begin
          pend_valid <= 1'b0;
          if (pend_valid) begin
            out_kind   <= KIND_EXPIRY;
            out_status <= STS_OK;
            out_id     <= pend_id;
            out_last   <= 1'b1;
          end
        end else begin
          out_kind  <= KIND_STATUS;
          out_id    <= op_id;
          out_last  <= 1'b1;
          case (op_cmd)
            CMD_ARM: begin
              if (match_found || free_found) begin
                slot_valid[sel_idx]     <= 1'b1;
                slot_id[sel_idx]        <= op_id;
                slot_timeout[sel_idx]   <= op_tmo;
                slot_remaining[sel_idx] <= op_tmo;
                out_status              <= STS_OK;
              end else begin
                out_status <= STS_FULL;
              end
            end
            CMD_KICK: begin
              if (match_found) begin
                slot_remaining[match_idx] <= slot_timeout[match_idx];
                out_status                <= STS_OK;
              end else begin
                out_status <= STS_NOT_FOUND;
              end
            end
            CMD_DISARM: begin
              if (match_found) begin
                slot_valid[match_idx] <= 1'b0;
                out_status            <= STS_OK;
              end else begin
                out_status <= STS_NOT_FOUND;
              end
            end
            default: out_status <= STS_OK;
          endcase
        end
      end
    end
  end

endmodule

FILE: rtl/multi_channel_timeout_watchdog_top.sv
// Watchdog table of SLOTS slots, each holding a command id, a timeout and
// the time remaining.
// req channel: one request per operation (arm, kick, disarm, tick).
// res channel: arm, kick and disarm each give one status result; a tick
// gives one expiry notice per due slot, in slot order, with last set on
// the final one, and nothing when no slot is due.
// Sequence: a request is taken when idle, then the table is walked
// one slot per cycle while res does not hold the walk, then one finish
// step. The next request is taken the cycle after finish, so a request
// is not taken before the walk and finish of the last are through.
// A status result is registered at finish and is valid on res after it;
// expiry notices trail their slot, because each is held until the next due
// slot or the end of the walk decides its last flag.
// res has an output register: while res is stalled, the walk holds at a
// slot with a notice to hand over, and finish waits unless a tick has none.
// Reset (rst, synchronous) frees every slot, drops any pending result and
// returns to idle with req ready.
`include "multi_channel_timeout_watchdog_top_macros.svh"

module multi_channel_timeout_watchdog_top import mcw_pkg::*; (
  input logic       clk,
  input logic       rst,
  mcw_req_if.sink   req,
  mcw_res_if.source res
);

  ctl_cmd_t ctl_cmd;
  dp_st_t   dp_st;

  mcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (dp_st),
    .cmd       (ctl_cmd)
  );

  mcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (req.cmd),
    .in_cmd_id  (req.cmd_id),
    .in_timeout (req.timeout),
    .cmd        (ctl_cmd),
    .st         (dp_st),
    .res        (res)
  );

  `MCW_ASSERT(a_one_req, req.valid && req.ready |=> !req.ready, "request taken while busy")
  `MCW_ASSERT(a_step_room, ctl_cmd.step && dp_st.need_push |-> !dp_st.out_busy, "notice lost")
  `MCW_ASSERT(a_fin_room, ctl_cmd.fin |-> !dp_st.out_busy || (dp_st.is_tick && !dp_st.pend_valid), "result lost")
  `MCW_ASSERT_RST(a_rst_idle, rst |=> !res.valid && req.ready, "not idle after reset")

endmodule

FILE: dv/watchdog_table_checker.sv
module watchdog_table_checker import mcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  mcw_req_if   req,
  mcw_res_if   res,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t            kind;
    status_t          status;
    logic [ID_W-1:0]  id;
    logic             last;
  } wd_result_t;

  wd_result_t       expected_results[$];
  logic             slot_armed[SLOTS];
  logic [ID_W-1:0]  slot_cmd_id[SLOTS];
  logic [TMO_W-1:0] slot_tmo[SLOTS];
  logic [TMO_W-1:0] slot_left[SLOTS];
  int               mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_result(input kind_t k, input status_t s, input logic [ID_W-1:0] id,
                             input logic l);
    wd_result_t r;
    r = '{kind: k, status: s, id: id, last: l};
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_watchdog(input cmd_e_t c, input logic [ID_W-1:0] id,
                                  input logic [TMO_W-1:0] tmo);
    int hit;
    int free_slot;
    int n;
    hit       = -1;
    free_slot = -1;
    n         = 0;
    if (c == CMD_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_armed[i]) begin
          if (slot_left[i] <= 1) begin
            if (n < MAX_RESULTS) begin
              push_result(KIND_EXPIRY, STS_OK, slot_cmd_id[i], 1'b0);
              slot_armed[i] = 1'b0;
              n++;
            end else begin
              slot_left[i] = 1;
            end
          end else begin
            slot_left[i] = slot_left[i] - 1;
          end
        end
      end
      if (n > 0) expected_results[expected_results.size()-1].last = 1'b1;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_armed[i] && slot_cmd_id[i] == id && hit < 0) hit = i;
        if (!slot_armed[i] && free_slot < 0) free_slot = i;
      end
      if (c == CMD_ARM) begin
        if (hit < 0) hit = free_slot;
        if (hit < 0) begin
          push_result(KIND_STATUS, STS_FULL, id, 1'b1);
        end else begin
          slot_armed[hit]  = 1'b1;
          slot_cmd_id[hit] = id;
          slot_tmo[hit]    = tmo;
          slot_left[hit]   = tmo;
          push_result(KIND_STATUS, STS_OK, id, 1'b1);
        end
      end else if (hit < 0) begin
        push_result(KIND_STATUS, STS_NOT_FOUND, id, 1'b1);
      end else begin
        if (c == CMD_KICK) slot_left[hit] = slot_tmo[hit];
        else slot_armed[hit] = 1'b0;
        push_result(KIND_STATUS, STS_OK, id, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    wd_result_t got;
    wd_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_armed[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        got = '{kind: res.kind, status: res.status, id: res.expired_id, last: res.last};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d status=%0d id=%h last=%0b",
                                    got.kind, got.status, got.id, got.last));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.status !== want.status ||
              got.id !== want.id || got.last !== want.last) begin
            report_mismatch($sformatf(
              "result kind=%0d status=%0d id=%h last=%0b, wanted %0d %0d %h %0b",
              got.kind, got.status, got.id, got.last,
              want.kind, want.status, want.id, want.last));
          end
        end
      end
      if (req.valid && req.ready) predict_watchdog(req.cmd, req.cmd_id, req.timeout);
    end
    fail_count  <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

FILE: dv/multi_channel_timeout_watchdog_top_tb.sv
module multi_channel_timeout_watchdog_top_tb;
  import mcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 305;
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_SIZE   = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   sent = 0;
  int   fail_count;
  int   outstanding;
  int   holdoff_left = 0;
  bit   holdoff_done = 1'b0;
  int   quiet_cycles = 0;
  logic steady;
  logic [ID_W-1:0] id_pool[POOL_SIZE];

  mcw_req_if req_ch ();
  mcw_res_if res_ch ();

  multi_channel_timeout_watchdog_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  watchdog_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  assign steady = (sent >= 150 && sent < 210);

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.cmd     = CMD_TICK;
    req_ch.cmd_id  = '0;
    req_ch.timeout = '0;
    res_ch.ready   = 1'b0;
  end

  // result side: random stalls, one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      res_ch.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (sent == HOLD_AT && !holdoff_done) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady || ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_req(input cmd_e_t c, input logic [ID_W-1:0] id,
                          input logic [TMO_W-1:0] tmo);
    while (!steady && $urandom_range(0, 99) < 32) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.cmd_id  <= id;
    req_ch.timeout <= tmo;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent <= sent + 1;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [TMO_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 5);
    if (r < 90) return $urandom_range(6, 40);
    return $urandom;
  endfunction

  initial begin
    int r;
    cmd_e_t c;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(CMD_TICK, 32'h0000_1234, '0);
    send_req(CMD_KICK, 32'h0000_1234, '0);
    send_req(CMD_DISARM, 32'h0000_1234, '0);
    send_req(CMD_ARM, '0, '0);
    send_req(CMD_ARM, '1, '1);
    send_req(CMD_ARM, '0, 2);
    send_req(CMD_KICK, '0, '0);
    send_req(CMD_TICK, '1, '1);
    send_req(CMD_TICK, '0, '0);
    // fill the table behind the long-timeout entry, then overflow it
    for (int i = 2; i < 17; i++) send_req(CMD_ARM, id_pool[i], i % 4);
    send_req(CMD_ARM, id_pool[17], 5);
    send_req(CMD_TICK, '0, '0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) c = CMD_ARM;
      else if (r < 50) c = CMD_KICK;
      else if (r < 65) c = CMD_DISARM;
      else c = CMD_TICK;
      if (c == CMD_ARM) send_req(c, pick_id(), pick_timeout());
      else if (c == CMD_TICK) send_req(c, $urandom, $urandom);
      else send_req(c, pick_id(), $urandom);
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mcw_pkg.sv
rtl/mcw_req_if.sv
rtl/mcw_res_if.sv
rtl/mcw_ctrl.sv
rtl/mcw_datapath.sv
rtl/multi_channel_timeout_watchdog_top.sv
dv/watchdog_table_checker.sv
dv/multi_channel_timeout_watchdog_top_tb.sv
